// ----- rtl/mcrb_pkg.sv -----
// ----------------------------------------------------------------------------
// mcrb_pkg
// Shared constants, command codes and controller/datapath interface types of
// the multichannel overlap-add ring buffer core.
// ----------------------------------------------------------------------------
package mcrb_pkg;

  localparam int DEPTH     = 4096;
  localparam int CHANNELS  = 8;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int ADDR_W    = CH_W + PTR_W;
  localparam int MEM_DEPTH = DEPTH * CHANNELS;
  localparam int LEN_W     = PTR_W + 1;
  localparam int NCH_W     = CH_W + 1;
  localparam int SAMPLE_W  = 24;
  localparam int CMD_W     = 4;
  localparam int CNT_W     = 13;
  localparam int POS_W     = 12;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  localparam logic [CMD_W-1:0] CMD_WR_REPL    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_WR_ADD     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_RD         = 4'd2;
  localparam logic [CMD_W-1:0] CMD_RD_ADD     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RD_ADD_CLR = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLR_WR     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADV_WR     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_ADV_RD     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CATCHUP    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SET_PTRS   = 4'd9;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_CH  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_CNT = 2'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_POS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);
  localparam logic [NCH_W-1:0] NCH_RESET = NCH_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(DEPTH);
  localparam logic [NCH_W-1:0] NCH_MAX   = NCH_W'(CHANNELS);

  typedef struct packed {
    logic load;
    logic clear;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mem_op;
  } dp_status_t;

endpackage

// ----- rtl/mcrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcrb_ctrl
// Sequencer: clearing pass after reset, command latch, execute and
// read-modify-write steps.
// ----------------------------------------------------------------------------
module mcrb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  mcrb_pkg::dp_status_t dp_status_i,
  output mcrb_pkg::ctrl_cmd_t  ctrl_cmd_o,
  output logic                 busy
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_EXEC  = 4'b0100,
    S_MEM   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_cmd_o.load = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_CLEAR: begin
        ctrl_cmd_o.clear = 1'b1;
        if (dp_status_i.clear_last) state_d = S_IDLE;
      end
      S_EXEC: begin
        ctrl_cmd_o.exec = 1'b1;
        state_d         = dp_status_i.mem_op ? S_MEM : S_IDLE;
      end
      S_MEM: begin
        ctrl_cmd_o.finish = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/mcrb_datapath.sv -----
// ----------------------------------------------------------------------------
// mcrb_datapath
// Sample store, per-channel pointers, configuration registers, saturating
// adder and result registers.
// ----------------------------------------------------------------------------
module mcrb_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mcrb_pkg::ctrl_cmd_t                  ctrl_cmd_i,
  output mcrb_pkg::dp_status_t                 dp_status_o,
  input  logic                                 cfg_we_i,
  input  logic [mcrb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mcrb_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [mcrb_pkg::CMD_W-1:0]           cmd_i,
  input  logic [mcrb_pkg::CH_W-1:0]            channel_i,
  input  logic signed [mcrb_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic signed [mcrb_pkg::SAMPLE_W-1:0] addend_i,
  input  logic [mcrb_pkg::CNT_W-1:0]           count_i,
  input  logic [mcrb_pkg::POS_W-1:0]           position_i,
  output logic                                 done_o,
  output logic signed [mcrb_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [mcrb_pkg::STATUS_W-1:0]        status_o,
  output logic                                 saturated_o
);

  localparam int SW = mcrb_pkg::SAMPLE_W;

  logic [mcrb_pkg::CMD_W-1:0]  cmd_q;
  logic [mcrb_pkg::CH_W-1:0]   ch_q;
  logic signed [SW-1:0]        smp_q, add_q, rdata_q;
  logic [mcrb_pkg::CNT_W-1:0]  cnt_q;
  logic [mcrb_pkg::POS_W-1:0]  pos_q;

  logic [mcrb_pkg::LEN_W-1:0]  len_q, len_u;
  logic [mcrb_pkg::NCH_W-1:0]  nch_q, nch_u;
  logic [mcrb_pkg::PTR_W-1:0]  wr_ptr_q [mcrb_pkg::CHANNELS];
  logic [mcrb_pkg::PTR_W-1:0]  rd_ptr_q [mcrb_pkg::CHANNELS];
  logic [mcrb_pkg::ADDR_W-1:0] clr_cnt_q;

  logic [SW-1:0] mem_q [mcrb_pkg::MEM_DEPTH];

  logic                         bad_ch, mem_op, is_wr_side, write_slot, mem_we;
  logic [mcrb_pkg::PTR_W-1:0]   ptr_sel, ptr_bump, ptr_adv;
  logic [mcrb_pkg::LEN_W-1:0]   bump_sum, adv_sum;
  logic [mcrb_pkg::ADDR_W-1:0]  addr, mem_waddr;
  logic [SW-1:0]                mem_wdata;
  logic [mcrb_pkg::STATUS_W-1:0] status_c;
  logic                         ptr_ok;
  logic signed [SW-1:0]         add_a, sat_val, res_val;
  logic signed [SW:0]           sum;
  logic                         ovf;

  always_comb begin
    if (len_q == '0) len_u = mcrb_pkg::LEN_W'(1);
    else if (len_q > mcrb_pkg::LEN_MAX) len_u = mcrb_pkg::LEN_MAX;
    else len_u = len_q;
    if (nch_q == '0) nch_u = mcrb_pkg::NCH_W'(1);
    else if (nch_q > mcrb_pkg::NCH_MAX) nch_u = mcrb_pkg::NCH_MAX;
    else nch_u = nch_q;
  end

  assign bad_ch = (cmd_q <= mcrb_pkg::CMD_ADV_RD) && ({1'b0, ch_q} >= nch_u);
  assign mem_op = !bad_ch && (cmd_q <= mcrb_pkg::CMD_CLR_WR);

  assign is_wr_side = (cmd_q == mcrb_pkg::CMD_WR_REPL) || (cmd_q == mcrb_pkg::CMD_WR_ADD) ||
                      (cmd_q == mcrb_pkg::CMD_CLR_WR) || (cmd_q == mcrb_pkg::CMD_ADV_WR);
  assign write_slot = (cmd_q == mcrb_pkg::CMD_WR_REPL) || (cmd_q == mcrb_pkg::CMD_WR_ADD) ||
                      (cmd_q == mcrb_pkg::CMD_CLR_WR) || (cmd_q == mcrb_pkg::CMD_RD_ADD_CLR);

  assign ptr_sel  = is_wr_side ? wr_ptr_q[ch_q] : rd_ptr_q[ch_q];
  assign addr     = {ch_q, ptr_sel};
  assign bump_sum = {1'b0, ptr_sel} + mcrb_pkg::LEN_W'(1);
  assign ptr_bump = (bump_sum >= len_u) ? '0 : bump_sum[mcrb_pkg::PTR_W-1:0];
  assign adv_sum  = {1'b0, ptr_sel} + cnt_q;
  always_comb begin
    if (adv_sum >= len_u) ptr_adv = mcrb_pkg::PTR_W'(adv_sum - len_u);
    else ptr_adv = adv_sum[mcrb_pkg::PTR_W-1:0];
  end

  always_comb begin
    status_c = mcrb_pkg::STS_OK;
    if (bad_ch) begin
      status_c = mcrb_pkg::STS_BAD_CH;
    end else if ((cmd_q == mcrb_pkg::CMD_ADV_WR || cmd_q == mcrb_pkg::CMD_ADV_RD) &&
                 (cnt_q > len_u)) begin
      status_c = mcrb_pkg::STS_BAD_CNT;
    end else if ((cmd_q == mcrb_pkg::CMD_SET_PTRS) && ({1'b0, pos_q} >= len_u)) begin
      status_c = mcrb_pkg::STS_BAD_POS;
    end
  end
  assign ptr_ok = ctrl_cmd_i.exec && !mem_op && (status_c == mcrb_pkg::STS_OK);

  // saturating add, stored sample plus operand
  assign add_a   = (cmd_q == mcrb_pkg::CMD_WR_ADD) ? smp_q : add_q;
  assign sum     = (SW+1)'(add_a) + (SW+1)'(rdata_q);
  assign ovf     = sum[SW] != sum[SW-1];
  assign sat_val = ovf ? {sum[SW], {(SW-1){~sum[SW]}}} : sum[SW-1:0];
  assign res_val = (cmd_q == mcrb_pkg::CMD_RD) ? rdata_q : sat_val;

  always_comb begin
    if (ctrl_cmd_i.clear) begin
      mem_wdata = '0;
    end else begin
      case (cmd_q)
        mcrb_pkg::CMD_WR_REPL: mem_wdata = smp_q;
        mcrb_pkg::CMD_WR_ADD:  mem_wdata = sat_val;
        default:               mem_wdata = '0;
      endcase
    end
  end

  assign mem_we    = ctrl_cmd_i.clear || (ctrl_cmd_i.finish && write_slot);
  assign mem_waddr = ctrl_cmd_i.clear ? clr_cnt_q : addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (ctrl_cmd_i.exec) rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.load) begin
      cmd_q <= cmd_i;
      ch_q  <= channel_i;
      smp_q <= sample_in_i;
      add_q <= addend_i;
      cnt_q <= count_i;
      pos_q <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= mcrb_pkg::LEN_RESET;
      nch_q     <= mcrb_pkg::NCH_RESET;
      clr_cnt_q <= '0;
      for (int c = 0; c < mcrb_pkg::CHANNELS; c++) begin
        wr_ptr_q[c] <= '0;
        rd_ptr_q[c] <= '0;
      end
    end else begin
      if (ctrl_cmd_i.clear) clr_cnt_q <= clr_cnt_q + mcrb_pkg::ADDR_W'(1);
      if (ptr_ok) begin
        case (cmd_q)
          mcrb_pkg::CMD_ADV_WR: wr_ptr_q[ch_q] <= ptr_adv;
          mcrb_pkg::CMD_ADV_RD: rd_ptr_q[ch_q] <= ptr_adv;
          mcrb_pkg::CMD_CATCHUP: begin
            for (int c = 0; c < mcrb_pkg::CHANNELS; c++) begin
              if (mcrb_pkg::NCH_W'(c) < nch_u) rd_ptr_q[c] <= wr_ptr_q[0];
            end
          end
          mcrb_pkg::CMD_SET_PTRS: begin
            for (int c = 0; c < mcrb_pkg::CHANNELS; c++) begin
              if (mcrb_pkg::NCH_W'(c) < nch_u) begin
                wr_ptr_q[c] <= pos_q;
                rd_ptr_q[c] <= pos_q;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (ctrl_cmd_i.finish) begin
        if (is_wr_side) wr_ptr_q[ch_q] <= ptr_bump;
        else rd_ptr_q[ch_q] <= ptr_bump;
      end
      if (cfg_we_i && (cfg_index_i == mcrb_pkg::CFG_LENGTH ||
                       cfg_index_i == mcrb_pkg::CFG_CHANNELS)) begin
        if (cfg_index_i == mcrb_pkg::CFG_LENGTH) len_q <= cfg_data_i;
        else nch_q <= cfg_data_i[mcrb_pkg::NCH_W-1:0];
        for (int c = 0; c < mcrb_pkg::CHANNELS; c++) begin
          wr_ptr_q[c] <= '0;
          rd_ptr_q[c] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (ctrl_cmd_i.exec && !mem_op) || ctrl_cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.exec && !mem_op) begin
      sample_out_o <= '0;
      status_o     <= status_c;
      saturated_o  <= 1'b0;
    end else if (ctrl_cmd_i.finish) begin
      sample_out_o <= (cmd_q == mcrb_pkg::CMD_RD || cmd_q == mcrb_pkg::CMD_RD_ADD ||
                       cmd_q == mcrb_pkg::CMD_RD_ADD_CLR) ? res_val : '0;
      status_o     <= mcrb_pkg::STS_OK;
      saturated_o  <= ovf && (cmd_q == mcrb_pkg::CMD_WR_ADD || cmd_q == mcrb_pkg::CMD_RD_ADD ||
                              cmd_q == mcrb_pkg::CMD_RD_ADD_CLR);
    end
  end

  assign dp_status_o.clear_last = &clr_cnt_q;
  assign dp_status_o.mem_op     = mem_op;

endmodule

// ----- rtl/multichannel_overlap_add_ring_buffer_core.sv -----
// Sequencing: a start transfer is taken in the idle state; pointer commands then
// run an execute step, sample commands an execute step (registered store read)
// and a write-back step (store read-modify-write). Results are registered.
// A new command is taken only once busy is low again. done_o strobes each result once.
// Reset: a clearing pass zeroes all 32768 store entries, one per cycle, with busy
// high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// multichannel_overlap_add_ring_buffer_core
// Multichannel circular sample store with per-channel read and write pointers
// and saturating overlap-add access.
// ----------------------------------------------------------------------------
module multichannel_overlap_add_ring_buffer_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mcrb_pkg::CMD_W-1:0]           cmd_i,
  input  logic [mcrb_pkg::CH_W-1:0]            channel_i,
  input  logic signed [mcrb_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic signed [mcrb_pkg::SAMPLE_W-1:0] addend_i,
  input  logic [mcrb_pkg::CNT_W-1:0]           count_i,
  input  logic [mcrb_pkg::POS_W-1:0]           position_i,
  output logic                                 done_o,
  output logic signed [mcrb_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [mcrb_pkg::STATUS_W-1:0]        status_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mcrb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mcrb_pkg::CFG_W-1:0]           cfg_data_i
);

  mcrb_pkg::ctrl_cmd_t  ctrl_cmd;
  mcrb_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  mcrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .dp_status_i (dp_status),
    .ctrl_cmd_o  (ctrl_cmd),
    .busy        (busy)
  );

  mcrb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_cmd_i   (ctrl_cmd),
    .dp_status_o  (dp_status),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .addend_i     (addend_i),
    .count_i      (count_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .sample_out_o (sample_out_o),
    .status_o     (status_o),
    .saturated_o  (saturated_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result strobe right after start transfer");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

endmodule

// ----- dv/multichannel_overlap_add_ring_buffer_core_tb.sv -----
// ----------------------------------------------------------------------------
// multichannel_overlap_add_ring_buffer_core_tb
// Self-checking bench for the multichannel ring buffer core. A scoreboard class
// tracks the sample store, the per-channel pointers and the configuration, and
// predicts sample, status and saturation for every command transfer. Directed
// corner cases come first, then random traffic under several length and
// channel settings with varying start gaps.
// ----------------------------------------------------------------------------
module multichannel_overlap_add_ring_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcrb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 850;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [STATUS_W-1:0]        status;
    logic                       saturated;
  } ring_result_t;

  class ring_store_scoreboard;
    logic signed [SAMPLE_W-1:0] store [MEM_DEPTH];
    logic [PTR_W-1:0]           wr_ptr [CHANNELS];
    logic [PTR_W-1:0]           rd_ptr [CHANNELS];
    logic [CFG_W-1:0]           length_reg;
    logic [3:0]                 channels_reg;
    ring_result_t               pending [$];
    int                         mismatches;

    function new();
      foreach (store[i]) store[i] = '0;
      zero_pointers();
      length_reg   = CFG_W'(DEPTH);
      channels_reg = 4'd2;
      mismatches   = 0;
    endfunction

    function void zero_pointers();
      foreach (wr_ptr[i]) begin
        wr_ptr[i] = '0;
        rd_ptr[i] = '0;
      end
    endfunction

    function int used_length();
      if (length_reg < 1) return 1;
      if (length_reg > DEPTH) return DEPTH;
      return int'(length_reg);
    endfunction

    function int used_channels();
      if (channels_reg < 1) return 1;
      if (channels_reg > CHANNELS) return CHANNELS;
      return int'(channels_reg);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_LENGTH) begin
        length_reg = data;
        zero_pointers();
      end else if (idx == CFG_CHANNELS) begin
        channels_reg = data[3:0];
        zero_pointers();
      end
    endfunction

    function logic signed [SAMPLE_W-1:0] sat_sum(int a, int b, output logic clip);
      int s;
      s = a + b;
      clip = 1'b0;
      if (s > int'(SAMPLE_MAX)) begin
        clip = 1'b1;
        return SAMPLE_MAX;
      end
      if (s < int'(SAMPLE_MIN)) begin
        clip = 1'b1;
        return SAMPLE_MIN;
      end
      return SAMPLE_W'(s);
    endfunction

    function logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p, int len);
      return (int'(p) + 1 >= len) ? '0 : p + 1'b1;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                               logic signed [SAMPLE_W-1:0] smp,
                               logic signed [SAMPLE_W-1:0] add,
                               logic [CNT_W-1:0] cnt, logic [POS_W-1:0] pos);
      ring_result_t r;
      int           len;
      int           nch;
      int           slot;
      logic         clip;
      len = used_length();
      nch = used_channels();
      clip = 1'b0;
      r.sample = '0;
      r.status = STS_OK;
      if (cmd <= CMD_ADV_RD && int'(ch) >= nch) begin
        r.status = STS_BAD_CH;
      end else begin
        case (cmd)
          CMD_WR_REPL, CMD_WR_ADD, CMD_CLR_WR: begin
            slot = int'(ch) * DEPTH + int'(wr_ptr[ch]);
            if (cmd == CMD_WR_REPL) store[slot] = smp;
            else if (cmd == CMD_WR_ADD) store[slot] = sat_sum(store[slot], smp, clip);
            else store[slot] = '0;
            wr_ptr[ch] = next_ptr(wr_ptr[ch], len);
          end
          CMD_RD, CMD_RD_ADD, CMD_RD_ADD_CLR: begin
            slot = int'(ch) * DEPTH + int'(rd_ptr[ch]);
            if (cmd == CMD_RD) r.sample = store[slot];
            else r.sample = sat_sum(add, store[slot], clip);
            if (cmd == CMD_RD_ADD_CLR) store[slot] = '0;
            rd_ptr[ch] = next_ptr(rd_ptr[ch], len);
          end
          CMD_ADV_WR, CMD_ADV_RD: begin
            if (int'(cnt) > len) r.status = STS_BAD_CNT;
            else if (cmd == CMD_ADV_WR)
              wr_ptr[ch] = PTR_W'((int'(wr_ptr[ch]) + int'(cnt)) % len);
            else
              rd_ptr[ch] = PTR_W'((int'(rd_ptr[ch]) + int'(cnt)) % len);
          end
          CMD_CATCHUP: begin
            for (int c = 0; c < nch; c++) rd_ptr[c] = wr_ptr[0];
          end
          CMD_SET_PTRS: begin
            if (int'(pos) >= len) begin
              r.status = STS_BAD_POS;
            end else begin
              for (int c = 0; c < nch; c++) begin
                wr_ptr[c] = pos;
                rd_ptr[c] = pos;
              end
            end
          end
          default: ;
        endcase
      end
      r.saturated = clip;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_response(logic signed [SAMPLE_W-1:0] sample, logic [STATUS_W-1:0] sts,
                        logic sat);
      ring_result_t e;
      if (pending.size() == 0) begin
        report("result with no command outstanding");
      end else begin
        e = pending.pop_front();
        if (sample !== e.sample)
          report($sformatf("sample_out got %h exp %h", sample, e.sample));
        if (sts !== e.status)
          report($sformatf("sts got %0d exp %0d", sts, e.status));
        if (sat !== e.saturated)
          report($sformatf("saturated got %b exp %b", sat, e.saturated));
      end
    endtask
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start       = 1'b0;
  logic                       busy;
  logic [CMD_W-1:0]           cmd_i       = '0;
  logic [CH_W-1:0]            channel_i   = '0;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic signed [SAMPLE_W-1:0] addend_i    = '0;
  logic [CNT_W-1:0]           count_i     = '0;
  logic [POS_W-1:0]           position_i  = '0;
  logic                       done_o;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic [STATUS_W-1:0]        status_o;
  logic                       saturated_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_W-1:0]           cfg_data_i  = '0;

  ring_store_scoreboard tracker = new();
  int cycles = 0;

  multichannel_overlap_add_ring_buffer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .channel_i   (channel_i),
    .sample_in_i (sample_in_i),
    .addend_i    (addend_i),
    .count_i     (count_i),
    .position_i  (position_i),
    .done_o      (done_o),
    .sample_out_o(sample_out_o),
    .status_o    (status_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_response(sample_out_o, status_o, saturated_o);
  end

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_register(idx, data);
  endtask

  task configure(logic [CFG_W-1:0] len_val, logic [CFG_W-1:0] nch_val);
    write_register(CFG_LENGTH, len_val);
    write_register(CFG_CHANNELS, nch_val);
    cfg_valid_i <= 1'b0;
  endtask

  // Leaves start high; the next call or the caller decides when it drops.
  task issue_command(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                     logic signed [SAMPLE_W-1:0] smp, logic signed [SAMPLE_W-1:0] add,
                     logic [CNT_W-1:0] cnt, logic [POS_W-1:0] pos, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    channel_i   <= ch;
    sample_in_i <= smp;
    addend_i    <= add;
    count_i     <= cnt;
    position_i  <= pos;
    do @(posedge clk_i); while (busy);
    tracker.note_command(cmd, ch, smp, add, cnt, pos);
  endtask

  task drain();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'($urandom_range(255)) - 24'sd128;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task random_command(int idle_pct);
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  ch;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] pos;
    int               len;
    int               nch;
    int               r;
    len = tracker.used_length();
    nch = tracker.used_channels();
    r = $urandom_range(99);
    if (r < 62)      cmd = CMD_W'($urandom_range(CMD_CLR_WR, CMD_WR_REPL));
    else if (r < 90) cmd = CMD_W'($urandom_range(CMD_SET_PTRS, CMD_ADV_WR));
    else if (r < 95) cmd = CMD_W'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
    else             cmd = CMD_W'($urandom());
    if ($urandom_range(99) < 85) ch = CH_W'($urandom_range(nch - 1));
    else                         ch = CH_W'($urandom());
    r = $urandom_range(99);
    if (r < 70)      cnt = CNT_W'($urandom_range(len));
    else if (r < 80) cnt = CNT_W'(len);
    else             cnt = CNT_W'($urandom());
    if ($urandom_range(99) < 80) pos = POS_W'($urandom_range(len - 1));
    else                         pos = POS_W'($urandom());
    issue_command(cmd, ch, pick_sample(), pick_sample(), cnt, pos, idle_pct);
  endtask

  localparam int PHASES = 7;
  logic [CFG_W-1:0] phase_len [PHASES] = '{13'd16, 13'd1, 13'd4096, 13'd0, 13'd8191,
                                           13'd5, 13'd300};
  logic [CFG_W-1:0] phase_nch [PHASES] = '{13'd8, 13'd1, 13'd8, 13'd0, 13'd15,
                                           13'd3, 13'd4};
  int idle_by_third [3] = '{19, 60, 0};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: length 4096, two channels
    issue_command(CMD_WR_REPL, 3'd0, SAMPLE_MAX, '0, '0, '0, 19);
    issue_command(CMD_WR_REPL, 3'd0, SAMPLE_MIN, '0, '0, '0, 19);
    issue_command(CMD_SET_PTRS, 3'd7, '0, '0, '0, 12'd0, 19);
    issue_command(CMD_WR_ADD, 3'd0, SAMPLE_MAX, '0, '0, '0, 19);
    issue_command(CMD_WR_ADD, 3'd0, SAMPLE_MIN, '0, '0, '0, 19);
    issue_command(CMD_WR_ADD, 3'd1, 24'sh000123, '0, '0, '0, 19);
    issue_command(CMD_RD, 3'd0, '0, '0, '0, '0, 19);
    issue_command(CMD_RD_ADD, 3'd0, '0, SAMPLE_MIN, '0, '0, 19);
    issue_command(CMD_RD_ADD, 3'd1, '0, 24'sh7FF000, '0, '0, 19);
    issue_command(CMD_SET_PTRS, 3'd0, '0, '0, '0, 12'd0, 19);
    issue_command(CMD_RD_ADD_CLR, 3'd0, '0, SAMPLE_MAX, '0, '0, 19);
    issue_command(CMD_CATCHUP, 3'd5, '0, '0, '0, '0, 19);
    issue_command(CMD_RD, 3'd0, '0, '0, '0, '0, 19);
    issue_command(CMD_CLR_WR, 3'd1, '0, '0, '0, '0, 19);
    issue_command(CMD_RD, 3'd2, '0, '0, '0, '0, 19);
    issue_command(CMD_WR_REPL, 3'd7, SAMPLE_MAX, '0, '0, '0, 19);
    issue_command(CMD_ADV_WR, 3'd0, '0, '0, 13'd4096, '0, 19);
    issue_command(CMD_ADV_RD, 3'd1, '0, '0, 13'd4095, '0, 19);
    issue_command(CMD_ADV_WR, 3'd1, '0, '0, 13'd8191, '0, 19);
    issue_command(CMD_ADV_RD, 3'd0, '0, '0, 13'd0, '0, 19);
    issue_command(CMD_SET_PTRS, 3'd0, '0, '0, '0, 12'd4095, 19);
    issue_command(CMD_UNKNOWN_LO, 3'd0, SAMPLE_MAX, SAMPLE_MAX, 13'd8191, 12'd4095, 19);
    issue_command(CMD_UNKNOWN_HI, 3'd7, SAMPLE_MIN, SAMPLE_MIN, '0, '0, 19);
    drain();

    write_register(CFG_LENGTH, 13'd16);
    write_register(CFG_CHANNELS, 13'd2);
    write_register(CFG_SPARE_2, 13'h1555);
    write_register(CFG_SPARE_3, 13'h0AAA);
    cfg_valid_i <= 1'b0;
    issue_command(CMD_SET_PTRS, 3'd0, '0, '0, '0, 12'd16, 19);
    issue_command(CMD_ADV_RD, 3'd1, '0, '0, 13'd17, '0, 19);
    issue_command(CMD_ADV_WR, 3'd1, '0, '0, 13'd16, '0, 19);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      configure(phase_len[p], phase_nch[p]);
      for (int i = 0; i < RAND_ITEMS / PHASES; i++)
        random_command(idle_by_third[p * 3 / PHASES]);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
